// ===== design/lcsl_pkg.sv =====
// ----------------------------------------------------------------------------
// lcsl_pkg: shared types and constants for the longest common substring block
// Opcodes, field widths and the control bundle broadcast to the cell chain.
// ----------------------------------------------------------------------------
package lcsl_pkg;

    localparam int OP_W        = 2;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;
    localparam int MAX_LEN_DEF = 64;

    typedef logic [OP_W-1:0]  opcode_t;
    typedef logic [SYM_W-1:0] symbol_t;
    typedef logic [LEN_W-1:0] len_t;

    localparam opcode_t OP_APPEND = 2'd0;
    localparam opcode_t OP_STEP   = 2'd1;
    localparam opcode_t OP_END    = 2'd2;

    // Largest suffix length a cell can hold; lengths saturate here.
    localparam len_t LEN_SAT = '1;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic    step;    // second-string byte: update suffix length
        logic    append;  // first-string byte: the selected cell loads it
        logic    clear;   // drop the pair: empty every cell
        symbol_t symbol;
    } cell_ctl_t;

endpackage

// ===== design/lcsl_cell.sv =====
// ----------------------------------------------------------------------------
// lcsl_cell: one position of the first string
// Holds a stored byte, its suffix length and a running maximum that shifts
// toward the end of the chain.
// ----------------------------------------------------------------------------
module lcsl_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lcsl_pkg::cell_ctl_t ctl,
    input  logic               sel,
    input  lcsl_pkg::len_t     prev_len,
    input  lcsl_pkg::len_t     prev_best,
    output lcsl_pkg::len_t     len,
    output lcsl_pkg::len_t     best
);
    import lcsl_pkg::*;

    symbol_t text_reg;
    logic    valid_reg;
    logic    valid_next;
    len_t    len_reg;
    len_t    len_next;
    len_t    best_reg;
    len_t    best_next;
    len_t    best_tmp;

    always_comb
    begin
        valid_next = valid_reg;
        len_next   = len_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
            len_next   = '0;
        end
        else if (ctl.append && sel)
        begin
            valid_next = 1'b1;
            len_next   = '0;
        end
        else if (ctl.step)
        begin
            if (valid_reg && (text_reg == ctl.symbol))
                len_next = (prev_len == LEN_SAT) ? LEN_SAT : prev_len + len_t'(1);
            else
                len_next = '0;
        end

        // Fold in our own length and the neighbor's maximum.
        best_tmp  = (len_next > best_reg) ? len_next : best_reg;
        best_next = (prev_best > best_tmp) ? prev_best : best_tmp;
        if (ctl.clear)
            best_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            len_reg   <= '0;
            best_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            len_reg   <= len_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.append && sel)
            text_reg <= ctl.symbol;
    end

    assign len  = len_reg;
    assign best = best_reg;

endmodule

// ===== design/longest_common_substring_length.sv =====
// ----------------------------------------------------------------------------
// longest_common_substring_length: suffix-length table on a chain of cells
// Stores the first string one byte per cell, updates the whole column of
// suffix lengths per second-string byte and reports the longest match.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  input    | in_valid / in_ready  | opcode, symbol
//  output   | out_valid / out_ready| match_length, overflowed
//
//  Append, step and ignored opcodes are taken back to back while idle.
//  An end item holds the input for the transfer and then a drain, in which
//  the running maximum shifts one cell per cycle down the chain; the last
//  drain step reads it at the last cell and clears the pair.
//  The result sits in an output register; a stalled output only holds the
//  block when the next end item finishes its drain.
//  Reset clears every cell's length, maximum and valid bit, the count and flag.
// ----------------------------------------------------------------------------
module longest_common_substring_length #(
    parameter int MAX_LEN = lcsl_pkg::MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lcsl_pkg::opcode_t opcode,
    input  lcsl_pkg::symbol_t symbol,
    output logic              out_valid,
    input  logic              out_ready,
    output lcsl_pkg::len_t    match_length,
    output logic              overflowed
);
    import lcsl_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(MAX_LEN - 1);

    localparam logic [0:0] S_IDLE  = 1'b0;
    localparam logic [0:0] S_DRAIN = 1'b1;

    logic [0:0]       state_reg;
    logic [0:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] drain_reg;
    logic [CNT_W-1:0] drain_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    len_t             match_length_reg;
    logic             overflowed_reg;

    logic             accept;
    logic             finish;
    cell_ctl_t        ctl;

    len_t             len_w  [MAX_LEN];
    len_t             best_w [MAX_LEN];

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Hand the result over once the drain is done and the output slot is free.
    assign finish = (state_reg == S_DRAIN) && (drain_reg == DRAIN_LAST)
                    && (!out_valid_reg || out_ready);

    always_comb
    begin
        ctl.step   = accept && (opcode == OP_STEP);
        ctl.append = accept && (opcode == OP_APPEND) && (count_reg != CNT_FULL);
        ctl.clear  = finish;
        ctl.symbol = symbol;
    end

    always_comb
    begin
        state_next    = state_reg;
        drain_next    = drain_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_END))
                begin
                    state_next = S_DRAIN;
                    drain_next = '0;
                end
            end
            S_DRAIN:
            begin
                if (finish)
                    state_next = S_IDLE;
                else if (drain_reg != DRAIN_LAST)
                    drain_next = drain_reg + CNT_W'(1);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctl.append)
            count_next = count_reg + CNT_W'(1);
        else if (accept && (opcode == OP_APPEND))
            overflow_next = 1'b1;   // store full: drop the byte

        if (finish)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            drain_reg     <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_reg     <= drain_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload with the transfer into the output register.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            match_length_reg <= best_w[MAX_LEN-1];
            overflowed_reg   <= overflow_reg;
        end
    end

    // Cell k sees the old length and maximum of cell k-1; cell 0 sees zero.
    for (genvar k = 0; k < MAX_LEN; k++)
    begin : g_cell
        len_t prev_len;
        len_t prev_best;
        logic sel;

        if (k == 0)
        begin : g_head
            assign prev_len  = '0;
            assign prev_best = '0;
        end
        else
        begin : g_body
            assign prev_len  = len_w[k-1];
            assign prev_best = best_w[k-1];
        end

        assign sel = (count_reg == CNT_W'(k));

        lcsl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .sel       (sel),
            .prev_len  (prev_len),
            .prev_best (prev_best),
            .len       (len_w[k]),
            .best      (best_w[k])
        );
    end

    assign out_valid    = out_valid_reg;
    assign match_length = match_length_reg;
    assign overflowed   = overflowed_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for longest_common_substring_length
// Streams append, step, end and unused commands into the block. A predictor
// keeps its own copy of the stored string, the suffix-length column, the best
// length and the overflow flag. Every reported pair is checked field by field
// against that prediction, under several patterns of idle and stall cycles.
// ----------------------------------------------------------------------------
module tb;

    import lcsl_pkg::*;

    localparam int      STORE_DEPTH  = MAX_LEN_DEF;
    localparam int      CYCLE_LIMIT  = 1_000_000;
    // Long enough for two end-command drains, with slack.
    localparam int      DRAIN_CYCLES = 2 * STORE_DEPTH + 16;
    localparam int      HOLD_CYCLES  = 600;
    // Opcode 3 has no meaning; the block must ignore it.
    localparam opcode_t OP_UNUSED    = 2'd3;

    typedef struct {
        opcode_t op;
        symbol_t sym;
    } command_t;

    typedef struct {
        len_t match_len;
        logic dropped;
    } pair_report_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    in_valid     = 1'b0;
    logic    in_ready;
    opcode_t opcode       = OP_APPEND;
    symbol_t symbol       = '0;
    logic    out_valid;
    logic    out_ready    = 1'b0;
    len_t    match_length;
    logic    overflowed;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    longest_common_substring_length #(
        .MAX_LEN (STORE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_length (match_length),
        .overflowed   (overflowed)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    command_t     command_queue [$];   // commands waiting to be offered
    pair_report_t expected_reports [$]; // predicted results, oldest first
    int           commands_issued = 0; // commands queued, opcode 3 excluded
    int           mismatch_count  = 0;
    int           cycle_count     = 0;
    int           sender_idle_pct = 0;
    int           stall_pct       = 0;
    int           hold_left       = 0;
    logic         hold_kick       = 1'b0;
    logic         cmd_taken       = 1'b0;

    // Predictor copy of the suffix-length table.
    symbol_t      stored_text [STORE_DEPTH] = '{default: '0};
    len_t         suffix_len  [STORE_DEPTH] = '{default: '0};
    int           stored_count   = 0;
    len_t         longest_run    = '0;
    logic         store_overflow = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted command to the table copy
    // ------------------------------------------------------------------------
    task automatic apply_command(opcode_t op, symbol_t sym);
        len_t         above_left;
        pair_report_t report;
        case (op)
            OP_APPEND:
            begin
                // Drop the byte and flag it once the store is full.
                if (stored_count < STORE_DEPTH)
                begin
                    stored_text[stored_count] = sym;
                    suffix_len[stored_count]  = '0;
                    stored_count++;
                end
                else
                    store_overflow = 1'b1;
            end
            OP_STEP:
            begin
                // Walk downward so each cell still sees the old above-left length.
                for (int k = stored_count - 1; k >= 0; k--)
                begin
                    above_left = (k == 0) ? len_t'(0) : suffix_len[k-1];
                    if (stored_text[k] != sym)
                        suffix_len[k] = '0;
                    else if (above_left == LEN_SAT)
                        suffix_len[k] = LEN_SAT;
                    else
                        suffix_len[k] = above_left + 1'b1;
                    if (suffix_len[k] > longest_run)
                        longest_run = suffix_len[k];
                end
            end
            OP_END:
            begin
                // Report the pair, then empty everything for the next one.
                report.match_len = longest_run;
                report.dropped   = store_overflow;
                expected_reports.insert(expected_reports.size(), report);
                for (int k = 0; k < STORE_DEPTH; k++)
                    suffix_len[k] = '0;
                stored_count   = 0;
                longest_run    = '0;
                store_overflow = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_command(opcode_t op, symbol_t sym);
        command_t cmd;
        cmd.op  = op;
        cmd.sym = sym;
        command_queue.insert(command_queue.size(), cmd);
        if (op != OP_UNUSED)
            commands_issued++;
    endtask

    // Draw from a narrow alphabet around base so matches are frequent, or
    // from all 256 byte values.
    function automatic symbol_t pick_symbol(symbol_t base, int alpha);
        if (alpha >= 256)
            return symbol_t'($urandom_range(0, 255));
        return symbol_t'(base + $urandom_range(0, alpha - 1));
    endfunction

    // Queue one well-formed pair: appends, steps, end. Optionally plant a
    // slice of the first string inside the second, and slip one append in
    // among the steps.
    task automatic queue_pair(int first_len, int second_len, int alpha,
                              bit plant, bit late_append);
        symbol_t first_q [$];
        symbol_t second_q [$];
        symbol_t base;
        int      start;
        int      span;
        int      lead;
        base = symbol_t'($urandom_range(0, 255));
        for (int i = 0; i < first_len; i++)
            first_q.insert(first_q.size(), pick_symbol(base, alpha));
        if (plant && first_len > 0 && second_len > 0)
        begin
            start = $urandom_range(0, first_len - 1);
            span  = $urandom_range(1, (first_len - start < second_len) ?
                                      first_len - start : second_len);
            lead  = $urandom_range(0, second_len - span);
            for (int i = 0; i < lead; i++)
                second_q.insert(second_q.size(), pick_symbol(base, alpha));
            for (int i = 0; i < span; i++)
                second_q.insert(second_q.size(), first_q[start + i]);
            while (second_q.size() < second_len)
                second_q.insert(second_q.size(), pick_symbol(base, alpha));
        end
        else
        begin
            for (int i = 0; i < second_len; i++)
                second_q.insert(second_q.size(), pick_symbol(base, alpha));
        end
        foreach (first_q[i])
            push_command(OP_APPEND, first_q[i]);
        if ($urandom_range(0, 9) == 0)
            push_command(OP_UNUSED, symbol_t'($urandom_range(0, 255)));
        foreach (second_q[i])
        begin
            if (late_append && i == second_q.size() / 2)
                push_command(OP_APPEND, pick_symbol(base, alpha));
            push_command(OP_STEP, second_q[i]);
        end
        push_command(OP_END, symbol_t'($urandom_range(0, 255)));
    endtask

    // Mostly well-formed pairs with random content; the rest are bursts of
    // arbitrary commands that break the pair structure.
    task automatic queue_random_pairs(int budget);
        int target;
        int roll;
        int first_len;
        int second_len;
        int alpha;
        target = commands_issued + budget;
        while (commands_issued < target)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                repeat ($urandom_range(1, 10))
                    push_command(opcode_t'($urandom_range(0, 3)),
                                 symbol_t'($urandom_range(0, 255)));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    first_len = $urandom_range(0, 12);
                else if (roll < 94)
                    first_len = $urandom_range(13, STORE_DEPTH);
                else
                    first_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 16);
                second_len = (first_len > 12) ? $urandom_range(0, 70)
                                              : $urandom_range(0, 16);
                alpha = ($urandom_range(0, 99) < 60) ? $urandom_range(1, 4) : 256;
                queue_pair(first_len, second_len, alpha,
                           $urandom_range(0, 1), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    task automatic wait_queue_empty();
        while (command_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle, int stall, int budget);
        sender_idle_pct = idle;
        stall_pct       = stall;
        queue_random_pairs(budget);
        wait_queue_empty();
    endtask

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Hold valid and payload until
    // the transfer seen at the last rising edge, then offer the next command
    // or idle at the phase's rate.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_commands
        command_t next_cmd;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || cmd_taken)
        begin
            if (command_queue.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_cmd = command_queue.pop_front();
                opcode   <= next_cmd.op;
                symbol   <= next_cmd.sym;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall at the phase's rate, and hold off completely while a
    // long hold is running.
    always @(negedge clk)
        out_ready <= rst_n && (hold_left == 0) &&
                     ($urandom_range(0, 99) >= stall_pct);

    // Long hold-off, counted here so the sender keeps offering meanwhile.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Check a result
    // transfer against the oldest prediction, then feed an input transfer to
    // the predictor.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_transfers
        pair_report_t want;
        if (!rst_n)
            cmd_taken = 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                    note_mismatch($sformatf("result with none expected: length %0d flag %0b",
                                            match_length, overflowed));
                else
                begin
                    want = expected_reports.pop_front();
                    if (match_length !== want.match_len)
                        note_mismatch($sformatf("match_length %0d, expected %0d",
                                                match_length, want.match_len));
                    if (overflowed !== want.dropped)
                        note_mismatch($sformatf("overflowed %0b, expected %0b",
                                                overflowed, want.dropped));
                end
            end
            cmd_taken = in_valid && in_ready;
            if (cmd_taken)
                apply_command(opcode, symbol);
        end
    end

    // Watchdog: end the run if it takes far longer than any correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequence_main
        symbol_t full_text [$];

        // Directed: empty pair, byte extremes, ignored opcode, append after
        // steps, each string empty, a plain three-byte match.
        push_command(OP_END,    8'hFF);
        push_command(OP_APPEND, 8'h00);
        push_command(OP_APPEND, 8'hFF);
        push_command(OP_STEP,   8'hFF);
        push_command(OP_STEP,   8'h00);
        push_command(OP_END,    8'h00);
        push_command(OP_UNUSED, 8'hAA);
        push_command(OP_APPEND, 8'h5A);
        push_command(OP_STEP,   8'h5A);
        push_command(OP_APPEND, 8'hA5);
        push_command(OP_STEP,   8'hA5);
        push_command(OP_END,    8'h55);
        push_command(OP_APPEND, 8'h11);
        push_command(OP_END,    8'h11);
        push_command(OP_STEP,   8'h22);
        push_command(OP_END,    8'h22);
        push_command(OP_APPEND, 8'h01);
        push_command(OP_APPEND, 8'h02);
        push_command(OP_APPEND, 8'h03);
        push_command(OP_STEP,   8'h01);
        push_command(OP_STEP,   8'h02);
        push_command(OP_STEP,   8'h03);
        push_command(OP_END,    8'h80);

        // Hold reset, then release it on a falling edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_queue_empty();

        // A full store matched end to end gives the largest length; a long
        // first string with a late append covers the full-store drop.
        for (int i = 0; i < STORE_DEPTH; i++)
            full_text.insert(full_text.size(), symbol_t'($urandom_range(0, 255)));
        foreach (full_text[i])
            push_command(OP_APPEND, full_text[i]);
        foreach (full_text[i])
            push_command(OP_STEP, full_text[i]);
        push_command(OP_END, 8'h00);
        queue_pair(STORE_DEPTH + 8, 8, 3, 1'b1, 1'b1);

        // Random phases: no idling, idle sender, stalling receiver, both.
        run_phase(0,  0,  350);
        run_phase(76, 0,  300);
        run_phase(0,  76, 300);
        run_phase(11, 11, 250);

        // Pressure: hold the receiver off while short pairs keep arriving, so
        // the output register fills and the block stalls its input.
        sender_idle_pct = 0;
        stall_pct       = 0;
        @(negedge clk);
        hold_kick = 1'b1;
        @(negedge clk);
        hold_kick = 1'b0;
        repeat (12)
            queue_pair($urandom_range(0, 4), $urandom_range(0, 4), 2, 1'b1, 1'b0);
        wait_queue_empty();

        // Drain: every command transferred, every result back, then a quiet
        // stretch to catch stray results.
        while (command_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lcsl_pkg.sv
design/lcsl_cell.sv
design/longest_common_substring_length.sv
tb/tb.sv
